// ----- rtl/core/transparent_2bpp_sprite_blitter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sprite blitter checker
// Clocked on clk; all but the reset macro are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef TRANSPARENT_2BPP_SPRITE_BLITTER_MACROS_SVH
`define TRANSPARENT_2BPP_SPRITE_BLITTER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TSB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sprite blitter check failed");

// Next-cycle implication, disabled in reset
`define TSB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sprite blitter check failed");

// Next-cycle implication that also holds across reset
`define TSB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sprite blitter reset check failed");

`endif

// ----- rtl/core/tsb_pkg.sv -----
// ----------------------------------------------------------------------------
// tsb_pkg
// Shared types, register codes, constants and the pixel merge function of
// the 2bpp transparent sprite blitter.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int SCREEN_WIDTH_DEF = 240;
  localparam int WORK_DEPTH_DEF   = 2;
  localparam int RES_DEPTH_DEF    = 2;

  localparam logic [7:0] PIX_TRANSPARENT = 8'hFF;

  typedef enum logic [2:0] {
    REG_PALETTE_MAP  = 3'd0,
    REG_DEST_X       = 3'd1,
    REG_DEST_Y       = 3'd2,
    REG_BLIT_WIDTH   = 3'd3,
    REG_BLIT_HEIGHT  = 3'd4,
    REG_SOURCE_X     = 3'd5,
    REG_SOURCE_Y     = 3'd6,
    REG_SPRITE_WIDTH = 3'd7
  } tsb_reg_t;

  typedef struct packed {
    logic [31:0] palette_map;
    logic [7:0]  dest_x;
    logic [7:0]  dest_y;
    logic [7:0]  blit_width;
    logic [7:0]  blit_height;
    logic [7:0]  source_x;
    logic [7:0]  source_y;
    logic [8:0]  sprite_width;
  } tsb_cfg_t;

  typedef struct packed {
    logic [7:0]  sprite_byte;
    logic [15:0] old_first;
    logic [15:0] old_second;
  } tsb_req_t;

  typedef struct packed {
    logic [14:0] dest_addr;
    logic [15:0] new_first;
    logic [15:0] new_second;
    logic [13:0] next_source_offset;
    logic [14:0] next_dest_addr;
    logic        blit_done;
  } tsb_res_t;

  // One classified request: payload plus the walk position it belongs to
  typedef struct packed {
    logic [7:0]  sprite_byte;
    logic [15:0] old_first;
    logic [15:0] old_second;
    logic [5:0]  col;
    logic [7:0]  row;
    logic [5:0]  next_col;
    logic [7:0]  next_row;
    logic        done;
  } tsb_work_t;

  // Merge two palette-mapped pixels into an old halfword; transparent keeps old
  function automatic logic [15:0] merge_half(input logic [31:0] pal,
                                             input logic [15:0] old,
                                             input logic [1:0]  idx_lo,
                                             input logic [1:0]  idx_hi);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] t;
    lo = pal[{idx_lo, 3'b000} +: 8];
    hi = pal[{idx_hi, 3'b000} +: 8];
    t  = old;
    if (lo != PIX_TRANSPARENT) t[7:0]  = lo;
    if (hi != PIX_TRANSPARENT) t[15:8] = hi;
    return t;
  endfunction

endpackage

// ----- rtl/core/tsb_fifo.sv -----
// ----------------------------------------------------------------------------
// tsb_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tsb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  output logic             empty,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tsb_front.sv -----
// ----------------------------------------------------------------------------
// tsb_front
// Accepts sprite requests, walks the column/row counters and tags each
// request with its position, the following position and the done flag.
// ----------------------------------------------------------------------------
module tsb_front import tsb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tsb_cfg_t  cfg,
  input  logic      push,
  output logic      full,
  input  tsb_req_t  sprite_req,
  input  logic      work_full,
  output logic      work_push,
  output tsb_work_t work
);

  logic [5:0] column_step;
  logic [5:0] column_step_next;
  logic [7:0] row_count;
  logic [7:0] row_count_next;
  logic [7:0] width_m1;
  logic [5:0] last_col;
  logic [7:0] last_row;
  logic [5:0] col;
  logic [7:0] row;
  logic       at_last_col;
  logic       at_last_row;

  // Last byte index in a row and last row index; zero sizes act as minimal
  assign width_m1 = cfg.blit_width - 8'd1;
  assign last_col = (cfg.blit_width == 8'd0) ? 6'd0 : width_m1[7:2];
  assign last_row = (cfg.blit_height == 8'd0) ? 8'd0 : cfg.blit_height - 8'd1;

  // Clamp counters left past a shrunken bound
  assign col = (column_step > last_col) ? last_col : column_step;
  assign row = (row_count > last_row) ? last_row : row_count;

  assign at_last_col = (col == last_col);
  assign at_last_row = (row == last_row);

  // Advance the walk; wrap to the first byte after the last one
  always_comb begin
    if (!at_last_col) begin
      column_step_next = col + 6'd1;
      row_count_next   = row;
    end else begin
      column_step_next = 6'd0;
      row_count_next   = at_last_row ? 8'd0 : row + 8'd1;
    end
  end

  // Tag the request for the back end
  assign full      = work_full;
  assign work_push = push && !work_full;

  always_comb begin
    work.sprite_byte = sprite_req.sprite_byte;
    work.old_first   = sprite_req.old_first;
    work.old_second  = sprite_req.old_second;
    work.col         = col;
    work.row         = row;
    work.next_col    = column_step_next;
    work.next_row    = row_count_next;
    work.done        = at_last_col && at_last_row;
  end

  // Hold counters until a request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      column_step <= '0;
      row_count   <= '0;
    end else if (work_push) begin
      column_step <= column_step_next;
      row_count   <= row_count_next;
    end
  end

endmodule

// ----- rtl/core/tsb_back.sv -----
// ----------------------------------------------------------------------------
// tsb_back
// Carries out one tagged request: palette merge and address products in a
// registered stage, then the address sums into the result queue.
// ----------------------------------------------------------------------------
module tsb_back import tsb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  tsb_cfg_t  cfg,
  input  logic      work_empty,
  output logic      work_pop,
  input  tsb_work_t work,
  input  logic      res_full,
  output logic      res_push,
  output tsb_res_t  res
);

  // Width of a full pixel line offset: (dest_y + row) * SCREEN_WIDTH + dest_x
  localparam int LINE_RAW_W = $clog2(510 * SCREEN_WIDTH + 256);
  localparam int LINE_W     = (LINE_RAW_W > 16) ? LINE_RAW_W : 16;

  logic              s1_valid;
  logic              s1_ready;
  logic [LINE_W-1:0] s1_line_cur;
  logic [LINE_W-1:0] s1_line_next;
  logic [15:0]       s1_src_prod;
  logic [5:0]        s1_col;
  logic [5:0]        s1_next_col;
  logic [15:0]       s1_first;
  logic [15:0]       s1_second;
  logic              s1_done;

  logic [8:0]        dst_row_cur;
  logic [8:0]        dst_row_next;
  logic [8:0]        src_row;
  logic [LINE_W-1:0] line_cur;
  logic [LINE_W-1:0] line_next;
  logic [15:0]       src_prod;

  // Row sums and the products that need a register behind them
  assign dst_row_cur  = {1'b0, cfg.dest_y} + {1'b0, work.row};
  assign dst_row_next = {1'b0, cfg.dest_y} + {1'b0, work.next_row};
  assign src_row      = {1'b0, cfg.source_y} + {1'b0, work.next_row};

  assign line_cur  = LINE_W'(dst_row_cur) * LINE_W'(SCREEN_WIDTH) + LINE_W'(cfg.dest_x);
  assign line_next = LINE_W'(dst_row_next) * LINE_W'(SCREEN_WIDTH) + LINE_W'(cfg.dest_x);
  assign src_prod  = 16'(src_row) * 16'(cfg.sprite_width[8:2]);

  // Stage handshake: advance when the stage is empty or the result queue has room
  assign s1_ready = !s1_valid || !res_full;
  assign work_pop = !work_empty && s1_ready;
  assign res_push = s1_valid && !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= !work_empty;
    end
  end

  // Load the stage with products and merged pixels
  always_ff @(posedge clk) begin
    if (work_pop) begin
      s1_line_cur  <= line_cur;
      s1_line_next <= line_next;
      s1_src_prod  <= src_prod;
      s1_col       <= work.col;
      s1_next_col  <= work.next_col;
      s1_first     <= merge_half(cfg.palette_map, work.old_first,
                                 work.sprite_byte[7:6], work.sprite_byte[5:4]);
      s1_second    <= merge_half(cfg.palette_map, work.old_second,
                                 work.sprite_byte[3:2], work.sprite_byte[1:0]);
      s1_done      <= work.done;
    end
  end

  // Final sums; addresses and offset wrap to field widths
  always_comb begin
    res.dest_addr = 15'(s1_line_cur[LINE_W-1:1] + (LINE_W - 1)'({s1_col, 1'b0}));
    res.new_first = s1_first;
    res.new_second = s1_second;
    res.next_source_offset = 14'(s1_src_prod + 16'(cfg.source_x[7:2]) + 16'(s1_next_col));
    res.next_dest_addr = 15'(s1_line_next[LINE_W-1:1] + (LINE_W - 1)'({s1_next_col, 1'b0}));
    res.blit_done = s1_done;
  end

endmodule

// ----- rtl/core/transparent_2bpp_sprite_blitter.sv -----
// ----------------------------------------------------------------------------
// transparent_2bpp_sprite_blitter
// Palette-expanding 2bpp to 8bpp blitter with transparency, read-modify-write
// on framebuffer halfwords, one sprite byte per request.
// ----------------------------------------------------------------------------
// The blitter takes one sprite byte with its two old framebuffer halfwords
// every clock cycle while it is not full and returns one result per request
// in request order. A pushed request is first written into the request
// queue, then passes into the compute stage, whose row products (by the
// screen width and by the sheet stride) set the register boundary, and then
// its final address sums are written into the result queue. Each side
// stalls on its own: up to two requests wait between front and back and two
// results wait at the output. Configuration writes take effect at once and
// are meant for when nothing is in flight.
// ----------------------------------------------------------------------------
module transparent_2bpp_sprite_blitter import tsb_pkg::*; #(
  parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  parameter int WORK_DEPTH   = WORK_DEPTH_DEF,
  parameter int RES_DEPTH    = RES_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  tsb_req_t    sprite_req,
  output logic        empty,
  input  logic        pop,
  output tsb_res_t    blit_res
);

  localparam int WORK_W = $bits(tsb_work_t);
  localparam int RES_W  = $bits(tsb_res_t);

  tsb_cfg_t          cfg;
  logic              work_push;
  logic              work_full;
  logic              work_empty;
  logic              work_pop;
  tsb_work_t         work_in;
  tsb_work_t         work_head;
  logic [WORK_W-1:0] work_wdata;
  logic [WORK_W-1:0] work_rdata;
  logic              res_push;
  logic              res_full;
  tsb_res_t          res_in;
  logic [RES_W-1:0]  res_wdata;
  logic [RES_W-1:0]  res_rdata;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.palette_map  <= 32'hFFFF_FFFF;
      cfg.dest_x       <= 8'd0;
      cfg.dest_y       <= 8'd0;
      cfg.blit_width   <= 8'd4;
      cfg.blit_height  <= 8'd1;
      cfg.source_x     <= 8'd0;
      cfg.source_y     <= 8'd0;
      cfg.sprite_width <= 9'd4;
    end else if (cfg_we) begin
      unique case (tsb_reg_t'(cfg_index))
        REG_PALETTE_MAP:  cfg.palette_map  <= cfg_data;
        REG_DEST_X:       cfg.dest_x       <= cfg_data[7:0];
        REG_DEST_Y:       cfg.dest_y       <= cfg_data[7:0];
        REG_BLIT_WIDTH:   cfg.blit_width   <= cfg_data[7:0];
        REG_BLIT_HEIGHT:  cfg.blit_height  <= cfg_data[7:0];
        REG_SOURCE_X:     cfg.source_x     <= cfg_data[7:0];
        REG_SOURCE_Y:     cfg.source_y     <= cfg_data[7:0];
        REG_SPRITE_WIDTH: cfg.sprite_width <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Front end: counters and tagging
  tsb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .sprite_req (sprite_req),
    .work_full  (work_full),
    .work_push  (work_push),
    .work       (work_in)
  );

  assign work_wdata = work_in;
  assign work_head  = tsb_work_t'(work_rdata);

  // Queue between front and back
  tsb_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (WORK_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (work_push),
    .full  (work_full),
    .wdata (work_wdata),
    .empty (work_empty),
    .pop   (work_pop),
    .rdata (work_rdata)
  );

  // Back end: merge and addresses
  tsb_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_empty (work_empty),
    .work_pop   (work_pop),
    .work       (work_head),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  assign res_wdata = res_in;
  assign blit_res  = tsb_res_t'(res_rdata);

  // Result queue facing the consumer
  tsb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_wdata),
    .empty (empty),
    .pop   (pop),
    .rdata (res_rdata)
  );

endmodule

// ----- rtl/core/tsb_checker.sv -----
// ----------------------------------------------------------------------------
// tsb_checker
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
`include "transparent_2bpp_sprite_blitter_macros.svh"

module tsb_checker import tsb_pkg::*; #(
  parameter int WORK_DEPTH = WORK_DEPTH_DEF,
  parameter int RES_DEPTH  = RES_DEPTH_DEF
) (
  input logic     clk,
  input logic     rst,
  input logic     cfg_we,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input tsb_res_t blit_res
);

  localparam int CAPACITY = WORK_DEPTH + 1 + RES_DEPTH;
  localparam int OUT_W    = $clog2(CAPACITY + 2);

  logic [OUT_W-1:0] outstanding;
  logic             have_prev;
  logic [14:0]      prev_next_dest;
  logic             in_take;
  logic             out_take;

  assign in_take  = push && !full;
  assign out_take = pop && !empty;

  // Track requests in flight and the last promised address
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      have_prev   <= 1'b0;
    end else begin
      if (in_take && !out_take) begin
        outstanding <= outstanding + 1'b1;
      end else if (out_take && !in_take) begin
        outstanding <= outstanding - 1'b1;
      end
      if (cfg_we) begin
        have_prev <= 1'b0;
      end else if (out_take) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      prev_next_dest <= blit_res.next_dest_addr;
    end
  end

  `TSB_ASSERT_RST(a_reset_clears, rst, empty && !full)
  `TSB_ASSERT_NXT(a_result_holds, !empty && !pop, !empty && $stable(blit_res))
  `TSB_ASSERT_IMP(a_no_invented, outstanding == '0, empty)
  `TSB_ASSERT_IMP(a_addr_chain, out_take && have_prev, blit_res.dest_addr == prev_next_dest)

endmodule

bind transparent_2bpp_sprite_blitter tsb_checker #(
  .WORK_DEPTH (WORK_DEPTH),
  .RES_DEPTH  (RES_DEPTH)
) u_tsb_checker (.*);

// ----- verif/transparent_2bpp_sprite_blitter_tb.sv -----
// ----------------------------------------------------------------------------
// transparent_2bpp_sprite_blitter_tb
// Streams sprite bytes with old framebuffer halfwords into the blitter under
// a series of register settings. A shadow walk of the rectangle and a
// palette merge predict every framebuffer write, and the monitor compares
// each popped result field by field. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module transparent_2bpp_sprite_blitter_tb import tsb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W      = SCREEN_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 3000;
  localparam int ITEM_TARGET   = 390;
  localparam int TAIL_START    = 330;

  typedef enum logic [1:0] {ST_ITEM, ST_CFG, ST_DRAIN} stream_kind_t;

  typedef struct {
    stream_kind_t kind;
    tsb_req_t     req;
    tsb_reg_t     idx;
    logic [31:0]  data;
    int           gap;
    bit           calm;
  } stream_entry_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;
  logic        push       = 1'b0;
  logic        full;
  tsb_req_t    sprite_req = '0;
  logic        empty;
  logic        pop        = 1'b0;
  tsb_res_t    blit_res;

  stream_entry_t sprite_stream[$];
  tsb_res_t      fb_writes_q[$];

  tsb_cfg_t    shadow_cfg;
  logic [5:0]  walk_col;
  logic [7:0]  walk_row;

  bit  req_taken    = 1'b0;
  bit  tail_phase   = 1'b0;
  int  settle       = 0;
  int  stall_left   = 0;
  int  pop_mode_cnt = 0;
  bit  pop_stalls   = 1'b1;
  int  quiet_cycles = 0;
  int  mismatches   = 0;
  int  n_items      = 0;

  transparent_2bpp_sprite_blitter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .sprite_req (sprite_req),
    .empty      (empty),
    .pop        (pop),
    .blit_res   (blit_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Count and print one mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got 0x%0h want 0x%0h", what, got, want);
    mismatches++;
  endtask

  // Halfword address of a walk position
  function automatic logic [14:0] fb_addr(input int unsigned col, input int unsigned row);
    int unsigned line;
    int unsigned addr;
    line = (shadow_cfg.dest_y + row) * SCREEN_W + shadow_cfg.dest_x;
    addr = (line >> 1) + 2 * col;
    return addr[14:0];
  endfunction

  // Map two pixel indices through the palette; transparent keeps the old byte
  function automatic logic [15:0] blend(input logic [15:0] old, input logic [1:0] idx_lo,
                                        input logic [1:0] idx_hi);
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] t;
    lo = shadow_cfg.palette_map[8 * idx_lo +: 8];
    hi = shadow_cfg.palette_map[8 * idx_hi +: 8];
    t  = old;
    if (lo != 8'hFF) t = (t & 16'hFF00) | {8'h00, lo};
    if (hi != 8'hFF) t = (t & 16'h00FF) | {hi, 8'h00};
    return t;
  endfunction

  // Predict the framebuffer write of one sprite byte and advance the walk
  task automatic predict_blit(input tsb_req_t r, output tsb_res_t w);
    int unsigned bpr;
    int unsigned rows;
    int unsigned col;
    int unsigned row;
    int unsigned offs;
    bit          last_col;
    bit          last_row;
    bpr  = ((shadow_cfg.blit_width == 0 ? 4 : shadow_cfg.blit_width) + 3) >> 2;
    rows = shadow_cfg.blit_height == 0 ? 1 : shadow_cfg.blit_height;
    col  = walk_col;
    row  = walk_row;
    // clamp counters left past a shrunken bound
    if (col > bpr - 1) col = bpr - 1;
    if (row > rows - 1) row = rows - 1;
    w.dest_addr  = fb_addr(col, row);
    w.new_first  = blend(r.old_first, r.sprite_byte[7:6], r.sprite_byte[5:4]);
    w.new_second = blend(r.old_second, r.sprite_byte[3:2], r.sprite_byte[1:0]);
    last_col = (col == bpr - 1);
    last_row = (row == rows - 1);
    w.blit_done = last_col && last_row;
    if (!last_col) begin
      col++;
    end else begin
      col = 0;
      row = last_row ? 0 : row + 1;
    end
    walk_col = col[5:0];
    walk_row = row[7:0];
    offs = (shadow_cfg.source_y + walk_row) * (shadow_cfg.sprite_width >> 2)
           + (shadow_cfg.source_x >> 2) + walk_col;
    w.next_source_offset = offs[13:0];
    w.next_dest_addr     = fb_addr(walk_col, walk_row);
  endtask

  // Drive requests and register writes from the stream
  always @(negedge clk) begin : drive_req
    logic        nx_push;
    logic        nx_we;
    tsb_req_t    nx_req;
    logic [2:0]  nx_idx;
    logic [31:0] nx_data;
    nx_push = 1'b0;
    nx_we   = 1'b0;
    nx_req  = sprite_req;
    nx_idx  = cfg_index;
    nx_data = cfg_data;
    if (!rst) begin
      if (push && !req_taken) begin
        // hold the request until it is taken
        nx_push = 1'b1;
      end else if (sprite_stream.size() != 0) begin
        case (sprite_stream[0].kind)
          ST_ITEM: begin
            if (sprite_stream[0].gap > 0) begin
              sprite_stream[0].gap = sprite_stream[0].gap - 1;
            end else begin
              nx_push = 1'b1;
              nx_req  = sprite_stream[0].req;
              if (sprite_stream[0].calm) tail_phase = 1'b1;
              void'(sprite_stream.pop_front());
            end
          end
          ST_CFG: begin
            // write registers only once everything has drained
            if (fb_writes_q.size() == 0 && settle >= SETTLE_CYCLES) begin
              nx_we   = 1'b1;
              nx_idx  = sprite_stream[0].idx;
              nx_data = sprite_stream[0].data;
              void'(sprite_stream.pop_front());
            end
          end
          default: begin
            if (fb_writes_q.size() == 0 && settle >= SETTLE_CYCLES)
              void'(sprite_stream.pop_front());
          end
        endcase
      end
      if (nx_push || fb_writes_q.size() != 0) settle = 0;
      else if (settle < SETTLE_CYCLES) settle++;
    end
    push       <= nx_push;
    sprite_req <= nx_req;
    cfg_we     <= nx_we;
    cfg_index  <= nx_idx;
    cfg_data   <= nx_data;
  end

  // Drive pop with random stall bursts, none in the tail
  always @(negedge clk) begin : drive_pop
    if (pop_mode_cnt == 0) begin
      pop_stalls   = ($urandom_range(0, 2) != 0);
      pop_mode_cnt = 64;
    end else begin
      pop_mode_cnt--;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (pop_stalls && !tail_phase && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 16);
    end
  end

  // Track registers and requests, check every popped result
  always @(posedge clk) begin : monitor
    tsb_res_t want;
    tsb_res_t got;
    if (rst) begin
      shadow_cfg.palette_map  = 32'hFFFF_FFFF;
      shadow_cfg.dest_x       = 8'd0;
      shadow_cfg.dest_y       = 8'd0;
      shadow_cfg.blit_width   = 8'd4;
      shadow_cfg.blit_height  = 8'd1;
      shadow_cfg.source_x     = 8'd0;
      shadow_cfg.source_y     = 8'd0;
      shadow_cfg.sprite_width = 9'd4;
      walk_col  = '0;
      walk_row  = '0;
      req_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        case (tsb_reg_t'(cfg_index))
          REG_PALETTE_MAP:  shadow_cfg.palette_map  = cfg_data;
          REG_DEST_X:       shadow_cfg.dest_x       = cfg_data[7:0];
          REG_DEST_Y:       shadow_cfg.dest_y       = cfg_data[7:0];
          REG_BLIT_WIDTH:   shadow_cfg.blit_width   = cfg_data[7:0];
          REG_BLIT_HEIGHT:  shadow_cfg.blit_height  = cfg_data[7:0];
          REG_SOURCE_X:     shadow_cfg.source_x     = cfg_data[7:0];
          REG_SOURCE_Y:     shadow_cfg.source_y     = cfg_data[7:0];
          REG_SPRITE_WIDTH: shadow_cfg.sprite_width = cfg_data[8:0];
          default: ;
        endcase
      end
      req_taken = push && !full;
      if (req_taken) begin
        predict_blit(sprite_req, want);
        fb_writes_q.push_back(want);
      end
      if (pop && !empty) begin
        got = blit_res;
        if (fb_writes_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", got.dest_addr, 0);
        end else begin
          want = fb_writes_q.pop_front();
          if (got.dest_addr !== want.dest_addr)
            report_mismatch("dest_addr", got.dest_addr, want.dest_addr);
          if (got.new_first !== want.new_first)
            report_mismatch("new_first", got.new_first, want.new_first);
          if (got.new_second !== want.new_second)
            report_mismatch("new_second", got.new_second, want.new_second);
          if (got.next_source_offset !== want.next_source_offset)
            report_mismatch("next_source_offset", got.next_source_offset,
                            want.next_source_offset);
          if (got.next_dest_addr !== want.next_dest_addr)
            report_mismatch("next_dest_addr", got.next_dest_addr, want.next_dest_addr);
          if (got.blit_done !== want.blit_done)
            report_mismatch("blit_done", got.blit_done, want.blit_done);
        end
      end
      quiet_cycles = (req_taken || cfg_we || (pop && !empty)) ? 0 : quiet_cycles + 1;
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  task automatic queue_item(input logic [7:0] b, input logic [15:0] o1, input logic [15:0] o2,
                            input int gap, input bit calm);
    stream_entry_t e;
    e.kind = ST_ITEM;
    e.req  = '{sprite_byte: b, old_first: o1, old_second: o2};
    e.idx  = REG_PALETTE_MAP;
    e.data = '0;
    e.gap  = gap;
    e.calm = calm;
    sprite_stream.push_back(e);
    n_items++;
  endtask

  task automatic queue_cfg(input tsb_reg_t idx, input logic [31:0] v);
    stream_entry_t e;
    e.kind = ST_CFG;
    e.req  = '0;
    e.idx  = idx;
    e.data = v;
    e.gap  = 0;
    e.calm = 1'b0;
    sprite_stream.push_back(e);
  endtask

  task automatic queue_drain();
    stream_entry_t e;
    e.kind = ST_DRAIN;
    e.req  = '0;
    e.idx  = REG_PALETTE_MAP;
    e.data = '0;
    e.gap  = 0;
    e.calm = 1'b0;
    sprite_stream.push_back(e);
  endtask

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random upper bits above a narrow register's field
  function automatic logic [31:0] with_junk(input logic [31:0] v, input int width);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 3) == 0) return v | ((junk >> width) << width);
    return v;
  endfunction

  initial begin : stimulus
    logic [31:0] pal;
    int unsigned dx, dy, bw, bh, sx, sy, sw;
    int unsigned cur_w, cur_h, bpr, rect, cnt;
    bit          busy, calm, first;

    // transparent palette after reset: nothing changes
    queue_item(8'h00, 16'hFFFF, 16'h0000, 0, 1'b0);
    queue_item(8'hFF, 16'h1234, 16'hFFFF, 2, 1'b0);
    // mixed palette with one transparent entry
    queue_cfg(REG_PALETTE_MAP, 32'h00FF55AA);
    queue_item(8'h1B, 16'h0000, 16'hFFFF, 0, 1'b0);
    queue_item(8'hE4, 16'hA5A5, 16'h5A5A, 0, 1'b0);
    queue_item(8'hAA, 16'hFFFF, 16'hFFFF, 3, 1'b0);
    queue_item(8'h55, 16'h0000, 16'h0000, 0, 1'b0);
    queue_cfg(REG_PALETTE_MAP, 32'h00000000);
    queue_item(8'hFF, 16'hFFFF, 16'hFFFF, 0, 1'b0);
    // zero width and zero height act as one byte, one row
    queue_cfg(REG_BLIT_WIDTH, 32'd0);
    queue_cfg(REG_BLIT_HEIGHT, 32'd0);
    queue_item(8'h3C, 16'h8001, 16'h7FFE, 0, 1'b0);
    queue_item(8'hC3, 16'h0F0F, 16'hF0F0, 0, 1'b0);
    // stop mid-rectangle, then shrink both bounds under the counters
    queue_cfg(REG_PALETTE_MAP, 32'h12FF3456);
    queue_cfg(REG_BLIT_WIDTH, 32'd8);
    queue_cfg(REG_BLIT_HEIGHT, 32'd3);
    queue_cfg(REG_DEST_X, 32'd6);
    queue_cfg(REG_DEST_Y, 32'd10);
    queue_cfg(REG_SOURCE_X, 32'd8);
    queue_cfg(REG_SOURCE_Y, 32'd2);
    queue_cfg(REG_SPRITE_WIDTH, 32'd32);
    for (int i = 0; i < 5; i++)
      queue_item(8'($urandom), 16'($urandom), 16'($urandom), 0, 1'b0);
    queue_cfg(REG_BLIT_WIDTH, 32'd4);
    queue_cfg(REG_BLIT_HEIGHT, 32'd2);
    queue_item(8'h96, 16'h1111, 16'h2222, 0, 1'b0);
    queue_item(8'h69, 16'h3333, 16'h4444, 0, 1'b0);
    // field extremes: odd dest_x and wrapping addresses and offsets
    queue_cfg(REG_DEST_X, 32'd255);
    queue_cfg(REG_DEST_Y, 32'd255);
    queue_cfg(REG_BLIT_WIDTH, 32'd255);
    queue_cfg(REG_BLIT_HEIGHT, 32'd255);
    queue_cfg(REG_SOURCE_X, 32'd255);
    queue_cfg(REG_SOURCE_Y, 32'd255);
    queue_cfg(REG_SPRITE_WIDTH, 32'd511);
    for (int i = 0; i < 4; i++) queue_item(8'($urandom), rand_half(), rand_half(), 0, 1'b0);
    queue_drain();
    cur_w = 255;
    cur_h = 255;

    // random phases: new settings, then mostly whole rectangles
    first = 1'b1;
    while (n_items < ITEM_TARGET) begin
      calm = (n_items >= TAIL_START);
      busy = !calm && ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        0:       pal = 32'hFFFF_FFFF;
        1:       pal = 32'h0000_0000;
        default: begin
          pal = $urandom;
          for (int k = 0; k < 4; k++)
            if ($urandom_range(0, 3) == 0) pal[8*k +: 8] = 8'hFF;
        end
      endcase
      case ($urandom_range(0, 9))
        0:       dx = 0;
        1:       dx = 239;
        2:       dx = 255;
        3:       dx = $urandom_range(0, 239) | 1;
        default: dx = $urandom_range(0, 239) & ~1;
      endcase
      case ($urandom_range(0, 9))
        0:       dy = 0;
        1:       dy = 159;
        2:       dy = 255;
        default: dy = $urandom_range(0, 159);
      endcase
      case ($urandom_range(0, 11))
        0:       bw = 0;
        1:       bw = 1;
        2:       bw = 240;
        3:       bw = 255;
        default: bw = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 11))
        0:       bh = 0;
        1:       bh = 160;
        2:       bh = 255;
        default: bh = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 7))
        0:       sx = 0;
        1:       sx = 255;
        default: sx = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 7))
        0:       sy = 0;
        1:       sy = 255;
        default: sy = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 7))
        0:       sw = 4;
        1:       sw = 256;
        2:       sw = $urandom_range(0, 511);
        default: sw = $urandom_range(4, 64);
      endcase
      // write most registers; a skipped one keeps its old value
      if (first || $urandom_range(0, 3) != 0) queue_cfg(REG_PALETTE_MAP, pal);
      if (first || $urandom_range(0, 3) != 0) queue_cfg(REG_DEST_X, with_junk(dx, 8));
      if (first || $urandom_range(0, 3) != 0) queue_cfg(REG_DEST_Y, with_junk(dy, 8));
      if (first || $urandom_range(0, 3) != 0) begin
        queue_cfg(REG_BLIT_WIDTH, with_junk(bw, 8));
        cur_w = bw;
      end
      if (first || $urandom_range(0, 3) != 0) begin
        queue_cfg(REG_BLIT_HEIGHT, with_junk(bh, 8));
        cur_h = bh;
      end
      if (first || $urandom_range(0, 3) != 0) queue_cfg(REG_SOURCE_X, with_junk(sx, 8));
      if (first || $urandom_range(0, 3) != 0) queue_cfg(REG_SOURCE_Y, with_junk(sy, 8));
      if (first || $urandom_range(0, 3) != 0) queue_cfg(REG_SPRITE_WIDTH, with_junk(sw, 9));
      first = 1'b0;

      bpr  = ((cur_w == 0 ? 4 : cur_w) + 3) >> 2;
      rect = bpr * (cur_h == 0 ? 1 : cur_h);
      if (rect <= 32) begin
        cnt = rect * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) cnt += $urandom_range(1, 3);
      end else begin
        cnt = $urandom_range(1, 12);
      end
      for (int i = 0; i < cnt; i++) begin
        // the tail starts at a fixed item count, even inside a phase
        calm = (n_items >= TAIL_START);
        if (!calm && $urandom_range(0, 49) == 0) queue_drain();
        queue_item(8'($urandom), rand_half(), rand_half(),
                   (busy && !calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0,
                   calm);
      end
    end

    // release reset on a falling clock edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for the stream to be taken and every write to return
    while (sprite_stream.size() != 0 || push || fb_writes_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fb_writes_q.size() != 0)
      report_mismatch("writes never returned", fb_writes_q.size(), 0);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/tsb_pkg.sv
rtl/core/tsb_fifo.sv
rtl/core/tsb_front.sv
rtl/core/tsb_back.sv
rtl/core/transparent_2bpp_sprite_blitter.sv
rtl/core/tsb_checker.sv
verif/transparent_2bpp_sprite_blitter_tb.sv
